/* design/rfc_pkg.sv */
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and helpers for the reader frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

  // frame layout
  localparam int FrameBytes = 12;
  localparam int HdrLen     = 4;
  localparam int PosBits    = $clog2(FrameBytes);
  localparam int HoldBits   = 16;

  typedef logic [PosBits-1:0]  pos_t;
  typedef logic [HoldBits-1:0] hold_cnt_t;

  localparam pos_t PosHdrEnd = pos_t'(HdrLen);
  localparam pos_t PosStatus = pos_t'(4);
  localparam pos_t PosIdLast = pos_t'(8);
  localparam pos_t PosLast   = pos_t'(FrameBytes - 1);

  // header bytes
  localparam logic [7:0] Hdr0 = 8'h04;
  localparam logic [7:0] Hdr1 = 8'h0C;
  localparam logic [7:0] Hdr2 = 8'h02;
  localparam logic [7:0] Hdr3 = 8'h30;

  localparam logic [31:0] IdZero    = 32'h0000_0000;
  localparam logic [31:0] IdAllOnes = 32'hFFFF_FFFF;
  localparam logic [7:0]  StatusOk  = 8'h00;

  localparam logic [15:0] HoldTicksReset = 16'd1000;

  // result codes
  typedef enum logic [2:0] {
    OUT_REPORTED   = 3'd0,
    OUT_SUPPRESSED = 3'd1,
    OUT_CSUM_BAD   = 3'd2,
    OUT_STATUS_BAD = 3'd3,
    OUT_ID_BAD     = 3'd4
  } outcome_t;

  // input item kind
  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // configuration register indexes
  typedef enum logic {
    REG_DIRECTION  = 1'b0,
    REG_HOLD_TICKS = 1'b1
  } reg_idx_t;

  // frame assembler result for the byte being processed
  typedef struct packed {
    logic        done;
    outcome_t    code;     // OUT_REPORTED stands for "good frame"
    logic [31:0] card_id;
  } frame_res_t;

  // events toward the hold-off timer
  typedef struct packed {
    logic tick;
    logic good;
  } hold_evt_t;

  // expected header byte at a header position
  function automatic logic [7:0] header_byte(input logic [1:0] idx);
    logic [7:0] hb;
    case (idx)
      2'd0:    hb = Hdr0;
      2'd1:    hb = Hdr1;
      2'd2:    hb = Hdr2;
      default: hb = Hdr3;
    endcase
    return hb;
  endfunction

endpackage

`default_nettype wire

/* design/rfc_frame.sv */
// ----------------------------------------------------------------------------
// rfc_frame
// Frame assembler: header match, running XOR, status and id capture, checks.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_frame import rfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  input  wire logic [7:0] rx_byte,
  output frame_res_t      res
);

  pos_t        byte_position, byte_position_next;
  logic [7:0]  xor_sum, xor_sum_next;
  logic [7:0]  status_seen, status_seen_next;
  logic [31:0] id_shift, id_shift_next;

  // next state and frame result
  always_comb begin
    byte_position_next = byte_position;
    xor_sum_next       = xor_sum;
    status_seen_next   = status_seen;
    id_shift_next      = id_shift;
    res.done           = 1'b0;
    res.code           = OUT_REPORTED;
    res.card_id        = id_shift;

    if (byte_valid) begin
      if (byte_position < PosHdrEnd) begin
        if (rx_byte != header_byte(byte_position[1:0])) begin
          // realign: a header start byte opens a new frame
          if (rx_byte == Hdr0) begin
            byte_position_next = pos_t'(1);
            xor_sum_next       = rx_byte;
          end else begin
            byte_position_next = '0;
            xor_sum_next       = '0;
          end
        end else begin
          xor_sum_next       = (byte_position == '0) ? rx_byte : (xor_sum ^ rx_byte);
          byte_position_next = byte_position + pos_t'(1);
        end
      end else if (byte_position < PosLast) begin
        if (byte_position == PosStatus) begin
          status_seen_next = rx_byte;
        end else if (byte_position <= PosIdLast) begin
          id_shift_next = {id_shift[23:0], rx_byte};
        end
        xor_sum_next       = xor_sum ^ rx_byte;
        byte_position_next = byte_position + pos_t'(1);
      end else begin
        // checksum byte closes the frame
        byte_position_next = '0;
        xor_sum_next       = '0;
        res.done           = 1'b1;
        if (rx_byte != ~xor_sum) begin
          res.code = OUT_CSUM_BAD;
        end else if (status_seen != StatusOk) begin
          res.code = OUT_STATUS_BAD;
        end else if (id_shift == IdZero || id_shift == IdAllOnes) begin
          res.code = OUT_ID_BAD;
        end else begin
          res.code = OUT_REPORTED;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      xor_sum       <= '0;
      status_seen   <= '0;
      id_shift      <= '0;
    end else begin
      byte_position <= byte_position_next;
      xor_sum       <= xor_sum_next;
      status_seen   <= status_seen_next;
      id_shift      <= id_shift_next;
    end
  end

endmodule

`default_nettype wire

/* design/rfc_holdoff.sv */
// ----------------------------------------------------------------------------
// rfc_holdoff
// Hold-off timer: disarms on a good frame, re-arms when the countdown expires.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_holdoff import rfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire hold_evt_t   evt,
  input  wire logic [15:0] hold_ticks,
  output logic             armed
);

  hold_cnt_t hold_count, hold_count_next;
  logic      armed_next;
  hold_cnt_t load;

  assign load = hold_cnt_t'(hold_ticks);

  // countdown; zero means idle
  always_comb begin
    armed_next      = armed;
    hold_count_next = hold_count;
    if (evt.good) begin
      armed_next      = 1'b0;
      hold_count_next = (load == '0) ? hold_cnt_t'(1) : load;
    end else if (evt.tick && hold_count != '0) begin
      hold_count_next = hold_count - hold_cnt_t'(1);
      if (hold_count == hold_cnt_t'(1)) begin
        armed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b1;
      hold_count <= '0;
    end else begin
      armed      <= armed_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

`default_nettype wire

/* design/rfid_frame_checker_debounce.sv */
// ----------------------------------------------------------------------------
// rfid_frame_checker_debounce
// Checks 12-byte reader frames and limits how often a card is reported.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                         tuser
//  s_*      in   [7:0] rx_byte                 [0] kind (0 byte, 1 tick)
//  m_*      out  [2:0] outcome, [34:3] card_id  -
//                [35] leaving, [39:36] zero
//  cfg_*    in   write port: index 0 direction, 1 hold_ticks
//
//  One item per cycle sustained while the result side does not stall; a
//  result passes through the input register, then the result register.
//  The frame assembler and hold-off timer both update in the single pass
//  between those two registers.
//  Synchronous reset empties both stages and resets all frame and timer state.
//  A stalled result holds the output register; the input register keeps
//  accepting until it is also full.
//
`default_nettype none

module rfid_frame_checker_debounce import rfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [2:0] outcome, [34:3] card_id, [35] leaving
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic        direction;
  logic [15:0] hold_ticks;

  logic        in_valid;
  kind_t       in_kind;
  logic [7:0]  in_byte;
  logic        advance;

  frame_res_t  res;
  hold_evt_t   evt;
  logic        armed;
  outcome_t    outcome;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      hold_ticks <= HoldTicksReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DIRECTION:  direction  <= cfg_data[0];
        REG_HOLD_TICKS: hold_ticks <= cfg_data;
      endcase
    end
  end

  // stage handshake: process when the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= kind_t'(s_tuser);
      in_byte <= s_tdata;
    end
  end

  rfc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (advance && in_kind == KIND_BYTE),
    .rx_byte    (in_byte),
    .res        (res)
  );

  assign evt.tick = advance && in_kind == KIND_TICK;
  assign evt.good = res.done && res.code == OUT_REPORTED;

  rfc_holdoff u_holdoff (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .hold_ticks (hold_ticks),
    .armed      (armed)
  );

  // a good frame while disarmed is a suppressed repeat
  assign outcome = (res.code == OUT_REPORTED && !armed) ? OUT_SUPPRESSED : res.code;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.done) begin
      m_tdata <= {4'b0000, direction, res.card_id, outcome};
    end
  end

endmodule

`default_nettype wire

/* design/rfc_checker.sv */
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks for the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_checker import rfc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // only defined outcome codes leave the block
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= OUT_ID_BAD)
    else $error("undefined outcome code");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:36] == 4'b0000)
    else $error("nonzero pad bits");

  // nothing is presented right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rfid_frame_checker_debounce rfc_checker u_rfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/tb_rfid_frame_checker_debounce.sv */
// ----------------------------------------------------------------------------
// tb_rfid_frame_checker_debounce
// Self-checking bench for the reader frame checker with report hold-off.
// A table of hand-built frames runs first, then random phases mixing good
// frames, damaged frames, junk bytes and tick bursts under several register
// settings. Each result transfer is checked against a hand-typed result from
// its table row or else against a cycle-free model of the frame assembler and
// hold-off timer. Both stream sides idle at random, and the result side holds
// off once for a long stretch.
`timescale 1ns / 1ps

module tb_rfid_frame_checker_debounce;
  import rfc_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 185;

  localparam logic [7:0] FRAME_HDR [4] = '{Hdr0, Hdr1, Hdr2, Hdr3};

  // one expected result
  typedef struct packed {
    outcome_t    code;
    logic [31:0] id;
    logic        leave;
  } card_result_t;

  // one input item as offered on the slave side
  typedef struct packed {
    kind_t        kind;
    logic [7:0]   data;
    logic         typed;  // want is typed in by hand
    card_result_t want;
  } stim_item_t;

  // directed table
  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_TICKS,
    ROW_JUNK,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t     op;
    reg_idx_t    idx;
    logic [31:0] val;       // card id, tick count or register value
    logic [7:0]  st;        // status byte
    logic [7:0]  flip;      // xor applied to the checksum byte
    logic [3:0]  ticks_in;  // ticks placed inside the frame
    logic        typed;
    outcome_t    code;
    logic        leave;
  } dir_row_t;

  localparam int NUM_ROWS = 19;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    // armed after reset: first good frame is reported
    '{ROW_FRAME, REG_DIRECTION, 32'h1234_5678, 8'h00, 8'h00, 4'd0, 1'b1, OUT_REPORTED,   1'b0},
    // same card again, ticks inside the frame
    '{ROW_FRAME, REG_DIRECTION, 32'h1234_5678, 8'h00, 8'h00, 4'd3, 1'b1, OUT_SUPPRESSED, 1'b0},
    '{ROW_TICKS, REG_DIRECTION, 32'd5,         8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    // checksum wins over bad status and bad id
    '{ROW_FRAME, REG_DIRECTION, 32'h0000_0000, 8'h80, 8'hFF, 4'd0, 1'b1, OUT_CSUM_BAD,   1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'hFFFF_FFFF, 8'hFF, 8'h00, 4'd0, 1'b1, OUT_STATUS_BAD, 1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'h0000_0000, 8'h00, 8'h00, 4'd0, 1'b1, OUT_ID_BAD,     1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'hFFFF_FFFF, 8'h00, 8'h00, 4'd0, 1'b1, OUT_ID_BAD,     1'b0},
    // header mismatches, then a frame that must resync
    '{ROW_JUNK,  REG_DIRECTION, 32'd0,         8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'h0000_0001, 8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    // zero hold time acts as one tick
    '{ROW_CFG,   REG_HOLD_TICKS, 32'd0,        8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_CFG,   REG_DIRECTION,  32'd1,        8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'h8000_0000, 8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_TICKS, REG_DIRECTION, 32'd1,         8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'hA5A5_A5A5, 8'h00, 8'h01, 4'd1, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'hA5A5_A5A5, 8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    // re-arm, then an idle tick
    '{ROW_TICKS, REG_DIRECTION, 32'd2,         8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'h00FF_00FF, 8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_CFG,   REG_HOLD_TICKS, 32'd65535,    8'h00, 8'h00, 4'd0, 1'b0, OUT_REPORTED,   1'b0},
    '{ROW_FRAME, REG_DIRECTION, 32'hFFFF_FFFE, 8'h00, 8'h00, 4'd2, 1'b0, OUT_REPORTED,   1'b0}
  };

  // DUT ports
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;  // [7:0] rx_byte
  logic        s_tuser   = 1'b0;   // [0] kind
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;            // [2:0] outcome, [34:3] card_id, [35] leaving
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = 16'h0000;

  rfid_frame_checker_debounce dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state
  logic [3:0]  fr_pos    = '0;
  logic [7:0]  fr_xor    = '0;
  logic [7:0]  fr_status = '0;
  logic [31:0] fr_id     = '0;
  logic        hold_armed = 1'b1;
  logic [15:0] hold_left  = '0;
  logic        cfg_dir    = 1'b0;
  logic [15:0] cfg_hold   = HoldTicksReset;

  stim_item_t   item_queue [$];
  card_result_t expected_cards [$];
  stim_item_t   cur_item;
  bit           have_item   = 0;
  int           tx_gap      = 0;
  bit           tx_burst    = 0;
  int           rx_gap      = 0;
  bit           rx_burst    = 0;
  logic         long_stall  = 1'b0;
  bit           random_on   = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  card_result_t step_res;

  // clock
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // frame assembler and hold-off timer, one input item per call
  function automatic bit card_step(input kind_t k, input logic [7:0] b,
                                   output card_result_t r);
    r = '0;
    if (k == KIND_TICK) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 16'd1;
        if (hold_left == 0) hold_armed = 1'b1;
      end
      return 0;
    end
    if (fr_pos < 4) begin
      if (b != FRAME_HDR[fr_pos[1:0]]) begin
        if (b == Hdr0) begin
          fr_pos = 4'd1;
          fr_xor = b;
        end else begin
          fr_pos = 4'd0;
          fr_xor = 8'h00;
        end
        return 0;
      end
      fr_xor = (fr_pos == 0) ? b : (fr_xor ^ b);
      fr_pos = fr_pos + 4'd1;
      return 0;
    end
    if (fr_pos < FrameBytes - 1) begin
      if (fr_pos == 4) fr_status = b;
      else if (fr_pos <= 8) fr_id = {fr_id[23:0], b};
      fr_xor = fr_xor ^ b;
      fr_pos = fr_pos + 4'd1;
      return 0;
    end
    // checksum byte closes the frame
    fr_pos = 4'd0;
    if (b != ~fr_xor) r.code = OUT_CSUM_BAD;
    else if (fr_status != StatusOk) r.code = OUT_STATUS_BAD;
    else if (fr_id == IdZero || fr_id == IdAllOnes) r.code = OUT_ID_BAD;
    else begin
      r.code = hold_armed ? OUT_REPORTED : OUT_SUPPRESSED;
      hold_armed = 1'b0;
      hold_left = (cfg_hold == 0) ? 16'd1 : cfg_hold;
    end
    fr_xor = 8'h00;
    r.id = fr_id;
    r.leave = cfg_dir;
    return 1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [39:0] got,
                               input logic [39:0] want);
    $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int pick_tx_gap();
    int r;
    if (tx_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // slave side: predict on each transfer, then offer the next item
  always @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      if (card_step(kind_t'(s_tuser), s_tdata, step_res))
        expected_cards.push_back(cur_item.typed ? cur_item.want : step_res);
      have_item = 0;
    end
    if (!rst && !have_item) begin
      if (tx_gap > 0) tx_gap--;
      else if (item_queue.size() != 0) begin
        cur_item = item_queue.pop_front();
        have_item = 1;
        tx_gap = pick_tx_gap();
        if ($urandom_range(0, 99) == 0) tx_burst = !tx_burst;
      end
    end
    s_tvalid <= have_item;
    s_tdata  <= cur_item.data;
    s_tuser  <= cur_item.kind;
  end

  // master side: check each transfer, then pick the next ready value
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (expected_cards.size() == 0) begin
        flag_mismatch("result with nothing expected", m_tdata, '0);
      end else begin
        card_result_t w;
        w = expected_cards.pop_front();
        if (m_tdata[2:0] != w.code)
          flag_mismatch("outcome", 40'(m_tdata[2:0]), 40'(w.code));
        if (m_tdata[34:3] != w.id)
          flag_mismatch("card_id", 40'(m_tdata[34:3]), 40'(w.id));
        if (m_tdata[35] != w.leave)
          flag_mismatch("leaving", 40'(m_tdata[35]), 40'(w.leave));
        if (m_tdata[39:36] != 4'h0)
          flag_mismatch("pad bits", 40'(m_tdata[39:36]), 40'h0);
      end
    end
    if (rst || long_stall) begin
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!rx_burst) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) rx_gap = $urandom_range(1, 3);
        else if (r < 23) rx_gap = $urandom_range(10, 60);
      end
      if ($urandom_range(0, 99) == 0) rx_burst = !rx_burst;
    end
  end

  // long receiver hold-off once the random part is running
  initial begin
    wait (random_on);
    repeat (50) @(posedge clk);
    long_stall <= 1'b1;
    repeat (400) @(posedge clk);
    long_stall <= 1'b0;
  end

  task automatic push_item(input kind_t k, input logic [7:0] d, input bit typed,
                           input card_result_t want);
    stim_item_t it;
    it.kind  = k;
    it.data  = d;
    it.typed = typed;
    it.want  = want;
    item_queue.push_back(it);
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++)
      push_item(KIND_TICK, 8'($urandom_range(0, 255)), 0, '0);
  endtask

  // one frame, possibly cut short, with ticks after byte six
  task automatic push_frame(input logic [7:0] st, input logic [31:0] id,
                            input logic [7:0] flip, input int ticks_in,
                            input int nbytes, input bit typed,
                            input card_result_t want);
    logic [7:0] fb [FrameBytes];
    logic [7:0] x;
    for (int i = 0; i < 4; i++) fb[i] = FRAME_HDR[i];
    fb[4] = st;
    fb[5] = id[31:24];
    fb[6] = id[23:16];
    fb[7] = id[15:8];
    fb[8] = id[7:0];
    fb[9] = 8'($urandom_range(0, 255));
    fb[10] = 8'($urandom_range(0, 255));
    x = 8'h00;
    for (int i = 0; i < FrameBytes - 1; i++) x = x ^ fb[i];
    fb[FrameBytes-1] = ~x ^ flip;
    for (int i = 0; i < nbytes; i++) begin
      push_item(KIND_BYTE, fb[i], typed && (i == FrameBytes - 1), want);
      if (i == 6) push_ticks(ticks_in);
    end
  endtask

  // block fully idle: nothing queued, offered or outstanding, plus margin
  task automatic wait_idle();
    do @(posedge clk);
    while (item_queue.size() != 0 || have_item || s_tvalid ||
           expected_cards.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_DIRECTION) cfg_dir = val[0];
    else cfg_hold = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // main sequence
  initial begin
    card_result_t want;
    int           pushed;
    int           r;
    int           tick_span;
    logic [31:0]  id;
    logic [15:0]  hold_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int n = 0; n < NUM_ROWS; n++) begin
      want.code  = DIR_ROWS[n].code;
      want.id    = DIR_ROWS[n].val;
      want.leave = DIR_ROWS[n].leave;
      case (DIR_ROWS[n].op)
        ROW_FRAME: push_frame(DIR_ROWS[n].st, DIR_ROWS[n].val, DIR_ROWS[n].flip,
                              DIR_ROWS[n].ticks_in, FrameBytes, DIR_ROWS[n].typed,
                              want);
        ROW_TICKS: push_ticks(DIR_ROWS[n].val);
        ROW_JUNK: begin
          // stray byte, header broken at its last byte, header broken by a new 04
          push_item(KIND_BYTE, Hdr3, 0, '0);
          push_item(KIND_BYTE, Hdr0, 0, '0);
          push_item(KIND_BYTE, Hdr1, 0, '0);
          push_item(KIND_BYTE, Hdr2, 0, '0);
          push_item(KIND_BYTE, 8'h55, 0, '0);
          push_item(KIND_BYTE, Hdr0, 0, '0);
          push_item(KIND_BYTE, Hdr1, 0, '0);
          push_item(KIND_BYTE, Hdr0, 0, '0);
        end
        default: begin
          wait_idle();
          write_cfg(DIR_ROWS[n].idx, DIR_ROWS[n].val[15:0]);
        end
      endcase
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin hold_val = 16'd1;     tick_span = 4;  end
        1: begin hold_val = 16'd65535; tick_span = 40; end
        2: begin
          hold_val = 16'($urandom_range(2, 40));
          tick_span = hold_val + 8;
        end
        default: begin hold_val = 16'd0; tick_span = 4; end
      endcase
      write_cfg(REG_DIRECTION, 16'(ph[0] ^ 1'b1));
      write_cfg(REG_HOLD_TICKS, hold_val);
      random_on = 1;
      pushed = 0;
      while (pushed < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // mostly well-formed frames
          if ($urandom_range(0, 9) == 0) id = $urandom_range(0, 1) ? IdAllOnes : IdZero;
          else id = $urandom;
          push_frame(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : StatusOk,
                     id,
                     ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                     FrameBytes, 0, '0);
          pushed += FrameBytes;
        end else if (r < 80) begin
          r = $urandom_range(1, tick_span);
          push_ticks(r);
          pushed += r;
        end else if (r < 90) begin
          // junk, sometimes looking like a header
          r = $urandom_range(1, 6);
          for (int j = 0; j < r; j++)
            push_item(KIND_BYTE, ($urandom_range(0, 3) == 0) ? FRAME_HDR[j % 4] :
                      8'($urandom_range(0, 255)), 0, '0);
          pushed += r;
        end else begin
          // frame cut short
          r = $urandom_range(1, FrameBytes - 1);
          push_frame(StatusOk, $urandom, 8'h00, 0, r, 0, '0);
          pushed += r;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
design/rfc_pkg.sv
design/rfc_frame.sv
design/rfc_holdoff.sv
design/rfid_frame_checker_debounce.sv
design/rfc_checker.sv
tb/tb_rfid_frame_checker_debounce.sv
